### rtl/itoa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itoa_pkg
// Shared constants and codes for the integer-to-ASCII formatter.
// ----------------------------------------------------------------------------
package itoa_pkg;

    localparam int VALUE_BITS    = 64;
    localparam int MAX_PRECISION = 60;

    // Digit slots: octal needs the most, and decimal never needs more.
    localparam int NUM_SLOTS = (VALUE_BITS + 2) / 3;
    localparam int SLOT_W    = $clog2(NUM_SLOTS);
    localparam int CNT_W     = $clog2(VALUE_BITS);

    localparam logic [2:0] OP_DEC  = 3'd0;
    localparam logic [2:0] OP_OCT  = 3'd1;
    localparam logic [2:0] OP_LHEX = 3'd2;
    localparam logic [2:0] OP_UHEX = 3'd3;
    localparam logic [2:0] OP_PTR  = 3'd4;

    localparam logic [1:0] SIGN_NONE  = 2'd0;
    localparam logic [1:0] SIGN_MINUS = 2'd1;
    localparam logic [1:0] SIGN_PLUS  = 2'd2;
    localparam logic [1:0] SIGN_SPACE = 2'd3;

endpackage

### rtl/itoa_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itoa_in_if
// Request channel: one integer conversion with its options.
// ----------------------------------------------------------------------------
interface itoa_in_if
    import itoa_pkg::*;
();
    logic        valid;
    logic        ready;
    logic [2:0]  operation;
    logic [63:0] value;
    logic        precision_given;
    logic [5:0]  min_digits;
    logic        zero_fill;
    logic        alternate_form;
    logic [1:0]  sign_select;

    modport source (
        output valid, operation, value, precision_given, min_digits,
               zero_fill, alternate_form, sign_select,
        input  ready
    );
    modport sink (
        input  valid, operation, value, precision_given, min_digits,
               zero_fill, alternate_form, sign_select,
        output ready
    );
endinterface

### rtl/itoa_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itoa_out_if
// Result channel: one formatted character per transfer; last marks a request's end.
interface itoa_out_if
    import itoa_pkg::*;
();
    logic       valid;
    logic       ready;
    logic [7:0] character;
    logic       char_valid;
    logic       emit_early;
    logic       zero_cleared;
    logic [1:0] width_reduction;
    logic       last;

    modport source (
        output valid, character, char_valid, emit_early, zero_cleared,
               width_reduction, last,
        input  ready
    );
    modport sink (
        input  valid, character, char_valid, emit_early, zero_cleared,
               width_reduction, last,
        output ready
    );
endinterface

### rtl/integer_to_ascii_formatter_top.sv
`timescale 1ns / 1ps
// Decimal runs the bit-serial binary-to-BCD shifter (S_CONV) over every value bit,
//   then the leading-zero scan (S_SCAN, one digit a cycle) and S_PREP before the
//   first character; other bases skip S_CONV. One character per cycle while the
//   sink takes them. A new request is taken only in S_IDLE, once the previous
//   request's last character has been registered.
// Reset: synchronous, active low; clears the sequencer and the output valid only.
// ----------------------------------------------------------------------------
// integer_to_ascii_formatter_top
// Formats one unsigned integer as printf would (sign/prefix, precision fill,
// digits), emitting one character per result, most significant first.
// ----------------------------------------------------------------------------
module integer_to_ascii_formatter_top
    import itoa_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    itoa_in_if.sink    i_req,
    itoa_out_if.source o_rsp
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CONV,
        S_SCAN,
        S_PREP,
        S_EMIT
    } t_state;

    t_state r_state;

    // Captured request
    logic [2:0]            r_op;
    logic                  r_pg;
    logic [5:0]            r_prec;
    logic                  r_zf;
    logic                  r_af;
    logic [1:0]            r_ss;
    logic                  r_vnz;

    // Shared digit unit: double-dabble shifter in decimal, plain digit store otherwise
    logic [VALUE_BITS-1:0]           r_val;
    logic [NUM_SLOTS-1:0][3:0]       r_dig;
    logic [CNT_W-1:0]                r_cnt;
    logic [SLOT_W-1:0]               r_idx;
    logic [5:0]                      r_nd;

    // Emission plan
    logic [5:0] r_n_left;
    logic [1:0] r_pre_left;
    logic [1:0] r_pn;
    logic       r_early;
    logic       r_zc;
    logic [1:0] r_wr;

    // Output register
    logic       r_o_valid;
    logic [7:0] r_o_char;
    logic       r_o_cv;
    logic       r_o_early;
    logic       r_o_zc;
    logic [1:0] r_o_wr;
    logic       r_o_last;

    logic [VALUE_BITS-1:0]    w_v;
    logic [3*NUM_SLOTS-1:0]   w_opad;
    logic [4*NUM_SLOTS-1:0]   w_hpad;
    logic [4*NUM_SLOTS-1:0]   w_load;
    logic [4*NUM_SLOTS-1:0]   w_adj;
    logic [4*NUM_SLOTS-1:0]   w_dabble;
    logic [5:0]               w_prec;
    logic [5:0]               w_n1;
    logic                     w_zc;
    logic [5:0]               w_n;
    logic [1:0]               w_pn;
    logic                     w_early;
    logic [1:0]               w_wr;
    logic [5:0]               w_pos;
    logic [3:0]               w_dsel;
    logic [7:0]               w_dchar;
    logic [7:0]               w_sign;
    logic [7:0]               w_pchar;
    logic                     w_slot_free;

    assign i_req.ready = (r_state == S_IDLE);
    assign w_slot_free = !r_o_valid || o_rsp.ready;

    assign w_v = i_req.value[VALUE_BITS-1:0];

    // Octal / hex digit load straight from the value bits
    always_comb begin
        w_opad = '0;
        w_hpad = '0;
        w_opad[VALUE_BITS-1:0] = w_v;
        w_hpad[VALUE_BITS-1:0] = w_v;
        w_load = w_hpad;
        if (i_req.operation == OP_OCT) begin
            for (int i = 0; i < NUM_SLOTS; i++) begin
                w_load[4*i +: 4] = {1'b0, w_opad[3*i +: 3]};
            end
        end
    end

    // One double-dabble step: add 3 to every BCD digit >= 5, then shift in a bit
    always_comb begin
        for (int i = 0; i < NUM_SLOTS; i++) begin
            w_adj[4*i +: 4] = (r_dig[i] >= 4'd5) ? r_dig[i] + 4'd3 : r_dig[i];
        end
        w_dabble = {w_adj[4*NUM_SLOTS-2:0], r_val[VALUE_BITS-1]};
    end

    always_comb begin
        if (!i_req.precision_given) begin
            w_prec = 6'd0;
        end else if (i_req.min_digits > 6'(MAX_PRECISION)) begin
            w_prec = 6'(MAX_PRECISION);
        end else begin
            w_prec = i_req.min_digits;
        end
    end

    // Plan: digit count with octal lead zero, precision fill, sign or prefix
    always_comb begin
        w_n1 = r_nd + 6'((r_op == OP_OCT) && r_af && (r_vnz || r_pg));
        w_zc = (r_op == OP_DEC) && (r_prec > w_n1);
        w_n  = (r_prec > w_n1) ? r_prec : w_n1;
        w_pn    = 2'd0;
        w_early = 1'b0;
        w_wr    = 2'd0;
        case (r_op)
            OP_DEC: begin
                if (r_ss != SIGN_NONE) begin
                    w_pn    = 2'd1;
                    w_early = r_zf && !w_zc;
                    w_wr    = w_early ? 2'd1 : 2'd0;
                end
            end
            OP_LHEX, OP_UHEX, OP_PTR: begin
                if ((r_op == OP_PTR) || (r_af && r_vnz)) begin
                    w_pn    = 2'd2;
                    w_early = r_zf;
                    w_wr    = r_zf ? 2'd2 : 2'd0;
                end
            end
            default: begin
                w_pn = 2'd0;
            end
        endcase
    end

    // Character selection
    always_comb begin
        w_pos  = r_n_left - 6'd1;
        w_dsel = r_dig[w_pos[SLOT_W-1:0]];
        if (w_pos < r_nd) begin
            w_dchar = {4'd0, w_dsel} + 8'h30;
            if (w_dsel > 4'd9) begin
                w_dchar = w_dchar + ((r_op == OP_UHEX) ? 8'd7 : 8'd39);
            end
        end else begin
            w_dchar = 8'h30;
        end
        case (r_ss)
            SIGN_MINUS: w_sign = 8'h2d;
            SIGN_PLUS:  w_sign = 8'h2b;
            default:    w_sign = 8'h20;
        endcase
        if (r_pre_left == 2'd2) begin
            w_pchar = 8'h30;
        end else if (r_pn == 2'd2) begin
            w_pchar = (r_op == OP_UHEX) ? 8'h58 : 8'h78;
        end else begin
            w_pchar = w_sign;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_o_valid <= 1'b0;
        end else begin
            // in S_EMIT a taken slot is refilled below
            if (r_o_valid && o_rsp.ready && (r_state != S_EMIT)) begin
                r_o_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_req.valid) begin
                        r_op   <= i_req.operation;
                        r_pg   <= i_req.precision_given;
                        r_prec <= w_prec;
                        r_zf   <= i_req.zero_fill;
                        r_af   <= i_req.alternate_form;
                        r_ss   <= i_req.sign_select;
                        r_vnz  <= (w_v != '0);
                        r_val  <= w_v;
                        r_cnt  <= '0;
                        r_idx  <= SLOT_W'(NUM_SLOTS - 1);
                        if (i_req.operation == OP_DEC) begin
                            r_dig   <= '0;
                            r_state <= S_CONV;
                        end else if (i_req.operation <= OP_PTR) begin
                            r_dig   <= w_load;
                            r_state <= S_SCAN;
                        end
                        // unused codes: dropped, no result
                    end
                end
                S_CONV: begin
                    r_dig <= w_dabble;
                    r_val <= {r_val[VALUE_BITS-2:0], 1'b0};
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == CNT_W'(VALUE_BITS - 1)) begin
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    // leading-zero scan, top slot down
                    if ((r_dig[r_idx] != 4'd0) || (r_idx == '0)) begin
                        r_nd    <= (!r_vnz && r_pg) ? 6'd0 : 6'(r_idx) + 6'd1;
                        r_state <= S_PREP;
                    end else begin
                        r_idx <= r_idx - 1'b1;
                    end
                end
                S_PREP: begin
                    r_n_left   <= w_n;
                    r_zc       <= w_zc;
                    r_pn       <= w_pn;
                    r_pre_left <= w_pn;
                    r_early    <= w_early;
                    r_wr       <= w_wr;
                    r_state    <= S_EMIT;
                end
                S_EMIT: begin
                    if (w_slot_free) begin
                        r_o_valid <= 1'b1;
                        r_o_zc    <= r_zc;
                        r_o_wr    <= r_wr;
                        if (r_pre_left != 2'd0) begin
                            r_o_char   <= w_pchar;
                            r_o_cv     <= 1'b1;
                            r_o_early  <= r_early;
                            r_o_last   <= (r_pre_left == 2'd1) && (r_n_left == 6'd0);
                            r_pre_left <= r_pre_left - 2'd1;
                            if ((r_pre_left == 2'd1) && (r_n_left == 6'd0)) begin
                                r_state <= S_IDLE;
                            end
                        end else if (r_n_left != 6'd0) begin
                            r_o_char  <= w_dchar;
                            r_o_cv    <= 1'b1;
                            r_o_early <= 1'b0;
                            r_o_last  <= (r_n_left == 6'd1);
                            r_n_left  <= r_n_left - 6'd1;
                            if (r_n_left == 6'd1) begin
                                r_state <= S_IDLE;
                            end
                        end else begin
                            // empty string: one marker result
                            r_o_char  <= 8'd0;
                            r_o_cv    <= 1'b0;
                            r_o_early <= 1'b0;
                            r_o_last  <= 1'b1;
                            r_state   <= S_IDLE;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_rsp.valid           = r_o_valid;
    assign o_rsp.character       = r_o_char;
    assign o_rsp.char_valid      = r_o_cv;
    assign o_rsp.emit_early      = r_o_early;
    assign o_rsp.zero_cleared    = r_o_zc;
    assign o_rsp.width_reduction = r_o_wr;
    assign o_rsp.last            = r_o_last;

endmodule
